[rtl/core/scancode_line_editor_core_assert.svh]
// assertion macros for the scancode line editor core
// used by the top level; no other dependencies
`ifndef SCANCODE_LINE_EDITOR_CORE_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_CORE_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sle_pkg.sv]
// shared types, codes and the set-1 key map for the scancode line editor
// no dependencies
`timescale 1ns / 1ps

package sle_pkg;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_BKSP   = 3'd2;
  localparam logic [2:0] ACT_ENTER  = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_SWITCH = 3'd5;
  localparam logic [2:0] ACT_READ   = 3'd6;

  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_ALT_REL    = 8'hB8;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_KEY_L      = 8'h26;
  localparam logic [7:0] SC_F1_REL     = 8'hBB;
  localparam logic [7:0] SC_F3_REL     = 8'hBD;
  localparam logic [7:0] SC_BKSP       = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic REQ_SCAN = 1'b0;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [1:0] terminal_index;
    logic [7:0] line_count;
    logic       shift_on;
    logic       caps_on;
    logic       ctrl_on;
    logic       alt_on;
    logic       use_mem;
  } sle_res_t;

  // ascii for a make code, zero when not printable
  function automatic logic [7:0] scan_key(input logic [7:0] code, input logic shift,
                                          input logic caps);
    logic [7:0] lo;
    logic [7:0] hi;
    logic       letter;
    logic       sel;
    begin
      {lo, hi, letter} = {8'h00, 8'h00, 1'b0};
      case (code)
        8'h02: {lo, hi, letter} = {"1", "!", 1'b0};
        8'h03: {lo, hi, letter} = {"2", "@", 1'b0};
        8'h04: {lo, hi, letter} = {"3", "#", 1'b0};
        8'h05: {lo, hi, letter} = {"4", "$", 1'b0};
        8'h06: {lo, hi, letter} = {"5", "%", 1'b0};
        8'h07: {lo, hi, letter} = {"6", "^", 1'b0};
        8'h08: {lo, hi, letter} = {"7", "&", 1'b0};
        8'h09: {lo, hi, letter} = {"8", "*", 1'b0};
        8'h0A: {lo, hi, letter} = {"9", "(", 1'b0};
        8'h0B: {lo, hi, letter} = {"0", ")", 1'b0};
        8'h0C: {lo, hi, letter} = {"-", "_", 1'b0};
        8'h0D: {lo, hi, letter} = {"=", "+", 1'b0};
        8'h0F: {lo, hi, letter} = {8'h09, 8'h09, 1'b0};
        8'h10: {lo, hi, letter} = {"q", "Q", 1'b1};
        8'h11: {lo, hi, letter} = {"w", "W", 1'b1};
        8'h12: {lo, hi, letter} = {"e", "E", 1'b1};
        8'h13: {lo, hi, letter} = {"r", "R", 1'b1};
        8'h14: {lo, hi, letter} = {"t", "T", 1'b1};
        8'h15: {lo, hi, letter} = {"y", "Y", 1'b1};
        8'h16: {lo, hi, letter} = {"u", "U", 1'b1};
        8'h17: {lo, hi, letter} = {"i", "I", 1'b1};
        8'h18: {lo, hi, letter} = {"o", "O", 1'b1};
        8'h19: {lo, hi, letter} = {"p", "P", 1'b1};
        8'h1A: {lo, hi, letter} = {"[", "{", 1'b0};
        8'h1B: {lo, hi, letter} = {"]", "}", 1'b0};
        8'h1E: {lo, hi, letter} = {"a", "A", 1'b1};
        8'h1F: {lo, hi, letter} = {"s", "S", 1'b1};
        8'h20: {lo, hi, letter} = {"d", "D", 1'b1};
        8'h21: {lo, hi, letter} = {"f", "F", 1'b1};
        8'h22: {lo, hi, letter} = {"g", "G", 1'b1};
        8'h23: {lo, hi, letter} = {"h", "H", 1'b1};
        8'h24: {lo, hi, letter} = {"j", "J", 1'b1};
        8'h25: {lo, hi, letter} = {"k", "K", 1'b1};
        8'h26: {lo, hi, letter} = {"l", "L", 1'b1};
        8'h27: {lo, hi, letter} = {";", ":", 1'b0};
        8'h28: {lo, hi, letter} = {8'h27, 8'h22, 1'b0};
        8'h29: {lo, hi, letter} = {8'h60, "~", 1'b0};
        8'h2B: {lo, hi, letter} = {8'h5C, "|", 1'b0};
        8'h2C: {lo, hi, letter} = {"z", "Z", 1'b1};
        8'h2D: {lo, hi, letter} = {"x", "X", 1'b1};
        8'h2E: {lo, hi, letter} = {"c", "C", 1'b1};
        8'h2F: {lo, hi, letter} = {"v", "V", 1'b1};
        8'h30: {lo, hi, letter} = {"b", "B", 1'b1};
        8'h31: {lo, hi, letter} = {"n", "N", 1'b1};
        8'h32: {lo, hi, letter} = {"m", "M", 1'b1};
        8'h33: {lo, hi, letter} = {",", "<", 1'b0};
        8'h34: {lo, hi, letter} = {".", ">", 1'b0};
        8'h35: {lo, hi, letter} = {"/", "?", 1'b0};
        8'h39: {lo, hi, letter} = {" ", " ", 1'b0};
        default: {lo, hi, letter} = {8'h00, 8'h00, 1'b0};
      endcase
      sel = letter ? (shift ^ caps) : shift;
      return sel ? hi : lo;
    end
  endfunction

endpackage

[rtl/core/scancode_line_editor_core.sv]
// scancode line editor: set-1 scancodes in, one edit/read result out per transaction
// keyboard line editor with one line per terminal in a shared line store, apb control register
// depends on sle_pkg, sle_ctrl, sle_ram and scancode_line_editor_core_assert.svh
//
// s channel: tuser = req_type (0 scancode, 1 read of a stored line byte),
//   tdata = scan_code, read_terminal, read_index
// m channel: tuser = action, tdata = char_code, terminal, line count, modifiers
// apb register 0 (address 0): input_enable, bit 0
// every accepted transaction gives exactly one result
// each result passes through the middle stage and then the output register that drives m_tvalid
// throughput: one transaction per cycle while m_tready does not hold the output; modifier, terminal and count state
//   sit in flops updated at accept, line bytes in a single-port ram whose
//   write or registered read is issued in the accept cycle
// m_tready low holds the output register and the middle stage; s_tready drops
//   only when both are full
// reset clears modifiers, active terminal, line counts and input_enable;
//   line store contents are not cleared and are only read below a line length
`timescale 1ns / 1ps
`include "scancode_line_editor_core_assert.svh"

module scancode_line_editor_core #(
  parameter int TERMINALS  = 3,
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // scan_code[7:0], read_terminal[9:8], read_index[16:10]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_code[7:0], terminal_index[9:8], line_count[17:10],
                                 // shift_on[18], caps_on[19], ctrl_on[20], alt_on[21]
  output logic [2:0]  m_tuser,   // action
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import sle_pkg::*;

  localparam int DEPTH  = TERMINALS * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              input_enable;
  logic              acc, s2_adv, s2_valid;
  sle_res_t          res, s2_res;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [7:0]        out_char;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, input_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_enable <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      input_enable <= pwdata[0];
    end
  end

  // handshake
  assign s2_adv   = !m_tvalid || m_tready;
  assign s_tready = !s2_valid || s2_adv;
  assign acc      = s_tvalid && s_tready;

  sle_ctrl #(
    .TERMINALS (TERMINALS),
    .LINE_BYTES(LINE_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .req_type     (s_tuser),
    .scan_code    (s_tdata[7:0]),
    .read_terminal(s_tdata[9:8]),
    .read_index   (s_tdata[16:10]),
    .input_enable (input_enable),
    .res          (res),
    .ram_en       (ram_en),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata)
  );

  sle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // middle stage waits for the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s_tready) begin
      s2_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_res <= res;
    end
  end

  assign out_char = s2_res.use_mem ? ram_rdata : s2_res.char_code;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      m_tuser <= s2_res.action;
      m_tdata <= {2'b00, s2_res.alt_on, s2_res.ctrl_on, s2_res.caps_on, s2_res.shift_on,
                  s2_res.line_count, s2_res.terminal_index, out_char};
    end
  end

  `SLE_ASSERT_IMP(a_no_ram_on_stall, clk, rst, s2_valid && !s2_adv, !ram_en,
                  "line store accessed while read data is held")
  `SLE_ASSERT_IMP(a_mem_only_read, clk, rst, s2_valid && s2_res.use_mem,
                  s2_res.action == ACT_READ, "ram data used for a non-read result")
  `SLE_ASSERT_NXT(a_accept_fills, clk, rst, acc, s2_valid,
                  "accepted transaction lost before middle stage")
  `SLE_ASSERT_IMP(a_write_scan_only, clk, rst, ram_we, acc && !s_tuser,
                  "line store written without an accepted scancode")

endmodule

[rtl/core/sle_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/core/sle_ctrl.sv]
// modifier, terminal and line count state with per-transaction decode
// depends on sle_pkg; drives the line store ram port
`timescale 1ns / 1ps

module sle_ctrl #(
  parameter int TERMINALS  = 3,
  parameter int LINE_BYTES = 128,
  parameter int ADDR_W     = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic              req_type,
  input  logic [7:0]        scan_code,
  input  logic [1:0]        read_terminal,
  input  logic [6:0]        read_index,
  input  logic              input_enable,
  output sle_pkg::sle_res_t res,
  output logic              ram_en,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_addr,
  output logic [7:0]        ram_wdata
);

  import sle_pkg::*;

  localparam int CW  = $clog2(LINE_BYTES);
  localparam int LW  = $clog2(LINE_BYTES + 1);
  localparam int TIW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam logic [ADDR_W-1:0] LB_A = ADDR_W'(LINE_BYTES);

  logic [CW-1:0]  edit_count [TERMINALS];
  logic [LW-1:0]  line_length [TERMINALS];
  logic [TIW-1:0] active_terminal;
  logic           shift_held, caps_lock, ctrl_held, alt_held;

  logic           shift_next, caps_next, ctrl_next, alt_next;
  logic           is_scan, do_clear, sw_code, sw_ok, do_switch;
  logic           do_bksp, do_add, do_enter;
  logic [7:0]     sw_idx;
  logic [TIW-1:0] term_next;
  logic [CW-1:0]  pos, pos_dec;
  logic [LW-1:0]  pos_inc;
  logic [7:0]     key;
  logic           rt_ok, hit;
  logic [LW-1:0]  ll_rd;
  logic [1:0]     t_sel;
  logic [ADDR_W-1:0] idx_sel;

  always_comb begin
    shift_next = shift_held;
    caps_next  = caps_lock;
    ctrl_next  = ctrl_held;
    alt_next   = alt_held;
    case (scan_code)
      SC_LSHIFT, SC_RSHIFT:         shift_next = 1'b1;
      SC_LSHIFT_REL, SC_RSHIFT_REL: shift_next = 1'b0;
      SC_ALT:                       alt_next   = 1'b1;
      SC_ALT_REL:                   alt_next   = 1'b0;
      SC_CTRL:                      ctrl_next  = 1'b1;
      SC_CTRL_REL:                  ctrl_next  = 1'b0;
      SC_CAPS:                      caps_next  = ~caps_lock;
      default: ;
    endcase
  end

  always_comb begin
    is_scan   = (req_type == REQ_SCAN);
    do_clear  = (scan_code == SC_KEY_L) && ctrl_next;
    sw_code   = alt_next && (scan_code inside {[SC_F1_REL:SC_F3_REL]});
    sw_idx    = scan_code - SC_F1_REL;
    sw_ok     = sw_idx < 8'(TERMINALS);
    do_switch = !do_clear && sw_code && sw_ok;
    term_next = do_switch ? TIW'(sw_idx) : active_terminal;
    pos       = edit_count[term_next];
    pos_dec   = pos - CW'(1);
    pos_inc   = LW'(pos) + LW'(1);
    key       = scan_key(scan_code, shift_next, caps_next);
    do_bksp   = !do_clear && !sw_code && (scan_code == SC_BKSP) && (pos != '0)
                && input_enable;
    do_add    = !do_clear && !sw_code && !do_bksp && (key != 8'h00)
                && (pos != CW'(LINE_BYTES - 1)) && input_enable;
    do_enter  = !do_clear && !sw_code && !do_bksp && !do_add
                && (scan_code == SC_ENTER) && input_enable;

    rt_ok = {1'b0, read_terminal} < 3'(TERMINALS);
    ll_rd = rt_ok ? line_length[read_terminal[TIW-1:0]] : '0;
    hit   = rt_ok && (9'(read_index) < 9'(ll_rd)) && (9'(read_index) < 9'(LINE_BYTES));

    res.shift_on = shift_next;
    res.caps_on  = caps_next;
    res.ctrl_on  = ctrl_next;
    res.alt_on   = alt_next;
    res.use_mem  = 1'b0;
    res.char_code      = 8'h00;
    res.terminal_index = 2'(term_next);
    res.line_count     = 8'(pos);
    res.action         = ACT_NONE;
    if (!is_scan) begin
      res.shift_on       = shift_held;
      res.caps_on        = caps_lock;
      res.ctrl_on        = ctrl_held;
      res.alt_on         = alt_held;
      res.action         = ACT_READ;
      res.terminal_index = read_terminal;
      res.line_count     = 8'(ll_rd);
      res.use_mem        = hit;
    end else if (do_clear) begin
      res.action     = ACT_CLEAR;
      res.line_count = 8'h00;
    end else if (do_switch) begin
      res.action = ACT_SWITCH;
    end else if (do_bksp) begin
      res.action     = ACT_BKSP;
      res.line_count = 8'(pos_dec);
    end else if (do_add) begin
      res.action     = ACT_ADD;
      res.char_code  = key;
      res.line_count = 8'(pos_inc);
    end else if (do_enter) begin
      res.action     = ACT_ENTER;
      res.char_code  = CH_NEWLINE;
      res.line_count = 8'(pos_inc);
    end

    ram_we    = acc && is_scan && (do_bksp || do_add || do_enter);
    ram_en    = ram_we || (acc && !is_scan && hit);
    t_sel     = is_scan ? 2'(active_terminal) : read_terminal;
    idx_sel   = !is_scan ? ADDR_W'(read_index) : (do_bksp ? ADDR_W'(pos_dec) : ADDR_W'(pos));
    ram_addr  = ADDR_W'(t_sel) * LB_A + idx_sel;
    ram_wdata = do_add ? key : (do_enter ? CH_NEWLINE : 8'h00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held      <= 1'b0;
      caps_lock       <= 1'b0;
      ctrl_held       <= 1'b0;
      alt_held        <= 1'b0;
      active_terminal <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        edit_count[i]  <= '0;
        line_length[i] <= '0;
      end
    end else if (acc && is_scan) begin
      shift_held      <= shift_next;
      caps_lock       <= caps_next;
      ctrl_held       <= ctrl_next;
      alt_held        <= alt_next;
      active_terminal <= term_next;
      if (do_clear) begin
        edit_count[active_terminal]  <= '0;
        line_length[active_terminal] <= '0;
      end else if (do_bksp) begin
        edit_count[active_terminal] <= pos_dec;
      end else if (do_add) begin
        edit_count[active_terminal] <= CW'(pos_inc);
      end else if (do_enter) begin
        edit_count[active_terminal]  <= '0;
        line_length[active_terminal] <= pos_inc;
      end
    end
  end

endmodule

[bench/tb.sv]
// self-checking bench for scancode_line_editor_core: directed keystroke table, then random
// typed lines, modifiers, terminal switches and line reads with random stalls on both streams
// depends on sle_pkg and the scancode_line_editor_core rtl
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  localparam int TERMINALS    = 3;
  localparam int LINE_BYTES   = 128;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SIDE_SEND    = 0;
  localparam int SIDE_RECV    = 1;
  localparam int DIR_ROWS     = 27;

  localparam logic       REQ_LINE_READ    = 1'b1;
  localparam logic [2:0] REG_INPUT_ENABLE = 3'd0;
  localparam logic [7:0] CH_TAB           = 8'h09;
  localparam logic [7:0] CH_SPACE         = 8'h20;
  localparam logic [7:0] SC_RELEASE       = 8'h80;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [1:0] terminal_index;
    logic [7:0] line_count;
    logic       shift_on;
    logic       caps_on;
    logic       ctrl_on;
    logic       alt_on;
  } edit_result_t;

  typedef struct packed {
    logic       req;
    logic [7:0] code;
    logic [1:0] rt;
    logic [6:0] ri;
  } keystroke_t;

  typedef struct packed {
    logic       cfg;
    logic       req;
    logic [7:0] code;
    logic [1:0] rt;
    logic [6:0] ri;
    logic       typed;
    logic [2:0] act;
    logic [7:0] ch;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // scan_code[7:0], read_terminal[9:8], read_index[16:10]
  logic        s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // char_code[7:0], terminal_index[9:8], line_count[17:10],
                          // shift_on[18], caps_on[19], ctrl_on[20], alt_on[21]
  logic [2:0]  m_tuser;   // action
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scancode_line_editor_core #(
    .TERMINALS (TERMINALS),
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // editor state mirror
  string num_keys = "1234567890-=!@#$%^&*()_+";
  string top_keys = "qwertyuiop[]QWERTYUIOP{}";
  string mid_keys = {"asdfghjkl;'", "\140", "ASDFGHJKL:\"~"};
  string low_keys = "\\zxcvbnm,./|ZXCVBNM<>?";

  logic       input_en;
  logic       shift_held, caps_lock, ctrl_held, alt_held;
  int         active_term;
  int         edit_cnt [TERMINALS];
  int         line_len [TERMINALS];
  logic [7:0] line_bytes [TERMINALS][LINE_BYTES];

  edit_result_t pending_results [$];
  keystroke_t   keystrokes [$];
  stim_row_t    dir_rows [DIR_ROWS];

  int calm_left [2];
  int act_count [8];
  int full_refusals;
  int enable_writes;
  int results_seen;
  int error_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic reset_mirror();
    input_en    = 1'b0;
    shift_held  = 1'b0;
    caps_lock   = 1'b0;
    ctrl_held   = 1'b0;
    alt_held    = 1'b0;
    active_term = 0;
    for (int t = 0; t < TERMINALS; t++) begin
      edit_cnt[t] = 0;
      line_len[t] = 0;
      for (int i = 0; i < LINE_BYTES; i++) line_bytes[t][i] = 8'h00;
    end
  endtask

  function automatic logic [7:0] key_to_ascii(input logic [7:0] code);
    logic sh;
    logic flip;
    sh   = shift_held;
    flip = caps_lock ^ shift_held;
    if (code >= 8'h02 && code <= 8'h0D) return num_keys[code - 8'h02 + (sh ? 12 : 0)];
    if (code >= 8'h10 && code <= 8'h1B)
      return top_keys[code - 8'h10 + (((code <= 8'h19) ? flip : sh) ? 12 : 0)];
    if (code >= 8'h1E && code <= 8'h29)
      return mid_keys[code - 8'h1E + (((code <= 8'h26) ? flip : sh) ? 12 : 0)];
    if (code >= 8'h2B && code <= 8'h35)
      return low_keys[code - 8'h2B +
                      (((code >= 8'h2C && code <= 8'h32) ? flip : sh) ? 11 : 0)];
    if (code == 8'h39) return CH_SPACE;
    if (code == 8'h0F) return CH_TAB;
    return 8'h00;
  endfunction

  function automatic edit_result_t predict_edit(input keystroke_t k);
    edit_result_t r;
    int           t;
    int           pos;
    logic [7:0]   key;
    r = '0;
    if (k.req == REQ_LINE_READ) begin
      r.action         = ACT_READ;
      r.terminal_index = k.rt;
      if (k.rt < TERMINALS) begin
        r.line_count = 8'(line_len[k.rt]);
        if (k.ri < line_len[k.rt]) r.char_code = line_bytes[k.rt][k.ri];
      end
    end else begin
      t = active_term;
      case (k.code)
        SC_LSHIFT, SC_RSHIFT:         shift_held = 1'b1;
        SC_LSHIFT_REL, SC_RSHIFT_REL: shift_held = 1'b0;
        SC_ALT:                       alt_held = 1'b1;
        SC_ALT_REL:                   alt_held = 1'b0;
        SC_CTRL:                      ctrl_held = 1'b1;
        SC_CTRL_REL:                  ctrl_held = 1'b0;
        SC_CAPS:                      caps_lock = ~caps_lock;
        default: ;
      endcase
      pos = edit_cnt[t];
      if (pos > LINE_BYTES - 1) pos = LINE_BYTES - 1;
      key = (k.code <= 8'h39) ? key_to_ascii(k.code) : 8'h00;
      if (k.code == SC_KEY_L && ctrl_held) begin
        edit_cnt[t] = 0;
        line_len[t] = 0;
        r.action    = ACT_CLEAR;
      end else if (alt_held && k.code >= SC_F1_REL && k.code <= SC_F3_REL) begin
        if (k.code - SC_F1_REL < TERMINALS) begin
          active_term = int'(k.code - SC_F1_REL);
          r.action    = ACT_SWITCH;
        end
      end else if (k.code == SC_BKSP && pos > 0 && input_en) begin
        pos--;
        line_bytes[t][pos] = 8'h00;
        edit_cnt[t]        = pos;
        r.action           = ACT_BKSP;
      end else if (key != 8'h00 && pos < LINE_BYTES - 1 && input_en) begin
        line_bytes[t][pos] = key;
        edit_cnt[t]        = pos + 1;
        r.action           = ACT_ADD;
        r.char_code        = key;
      end else if (k.code == SC_ENTER && input_en) begin
        line_bytes[t][pos] = CH_NEWLINE;
        line_len[t]        = pos + 1;
        edit_cnt[t]        = 0;
        r.action           = ACT_ENTER;
        r.char_code        = CH_NEWLINE;
      end
      if (r.action == ACT_NONE && key != 8'h00 && input_en && pos == LINE_BYTES - 1)
        full_refusals++;
      r.terminal_index = 2'(active_term);
      r.line_count     = 8'((r.action == ACT_ENTER) ? line_len[t] : edit_cnt[active_term]);
    end
    r.shift_on = shift_held;
    r.caps_on  = caps_lock;
    r.ctrl_on  = ctrl_held;
    r.alt_on   = alt_held;
    act_count[r.action]++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (error_count < 40)
      $display("mismatch in %s at result %0d: expected %0h, got %0h",
               what, results_seen, exp_v, got_v);
    error_count++;
  endtask

  function automatic int draw_gap(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_item(input keystroke_t k, input logic typed, input logic [2:0] t_act,
                           input logic [7:0] t_ch);
    int           gap;
    edit_result_t r;
    gap = draw_gap(SIDE_SEND);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k.req;
    s_tdata  <= {7'd0, k.ri, k.rt, k.code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_edit(k);
    if (typed) begin
      r.action    = t_act;
      r.char_code = t_ch;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_input_enable(input logic value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_INPUT_ENABLE;
    pwdata  <= {31'($urandom_range(0, 32'h7fff_ffff)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    input_en = value;
    enable_writes++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== value) report_mismatch("input_enable readback", value, rd[0]);
  endtask

  task automatic check_result();
    edit_result_t got;
    edit_result_t exp_r;
    got.action         = m_tuser;
    got.char_code      = m_tdata[7:0];
    got.terminal_index = m_tdata[9:8];
    got.line_count     = m_tdata[17:10];
    got.shift_on       = m_tdata[18];
    got.caps_on        = m_tdata[19];
    got.ctrl_on        = m_tdata[20];
    got.alt_on         = m_tdata[21];
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", 0, got);
    end else begin
      exp_r = pending_results.pop_front();
      if (got.action !== exp_r.action) report_mismatch("action", exp_r.action, got.action);
      if (got.char_code !== exp_r.char_code)
        report_mismatch("char_code", exp_r.char_code, got.char_code);
      if (got.terminal_index !== exp_r.terminal_index)
        report_mismatch("terminal_index", exp_r.terminal_index, got.terminal_index);
      if (got.line_count !== exp_r.line_count)
        report_mismatch("line_count", exp_r.line_count, got.line_count);
      if (got.shift_on !== exp_r.shift_on) report_mismatch("shift_on", exp_r.shift_on, got.shift_on);
      if (got.caps_on !== exp_r.caps_on) report_mismatch("caps_on", exp_r.caps_on, got.caps_on);
      if (got.ctrl_on !== exp_r.ctrl_on) report_mismatch("ctrl_on", exp_r.ctrl_on, got.ctrl_on);
      if (got.alt_on !== exp_r.alt_on) report_mismatch("alt_on", exp_r.alt_on, got.alt_on);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(SIDE_RECV);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic logic [7:0] random_printable();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(8'h02, 8'h0D));
      1:       return 8'($urandom_range(8'h10, 8'h1B));
      2:       return 8'($urandom_range(8'h1E, 8'h29));
      3:       return 8'($urandom_range(8'h2B, 8'h35));
      4:       return $urandom_range(0, 1) ? 8'h39 : 8'h0F;
      default: return 8'($urandom_range(8'h1E, 8'h26));
    endcase
  endfunction

  task automatic push_scan(input logic [7:0] code);
    keystroke_t k;
    k.req  = REQ_SCAN;
    k.code = code;
    k.rt   = 2'($urandom_range(0, 3));
    k.ri   = 7'($urandom_range(0, 127));
    keystrokes.push_back(k);
  endtask

  task automatic plan_keystrokes();
    int         pick;
    int         n;
    logic [7:0] shift_code;
    keystroke_t k;
    logic [7:0] modifiers [9];
    modifiers = '{SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_REL, SC_RSHIFT_REL, SC_CAPS,
                  SC_CTRL, SC_CTRL_REL, SC_ALT, SC_ALT_REL};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          shift_code = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
          push_scan(shift_code);
          push_scan(random_printable());
          push_scan(shift_code | SC_RELEASE);
        end else if ($urandom_range(0, 11) == 0) begin
          push_scan(SC_BKSP);
        end else begin
          push_scan(random_printable());
        end
      end
      if ($urandom_range(0, 4) != 0) push_scan(SC_ENTER);
    end else if (pick < 46) begin
      k.req  = REQ_LINE_READ;
      k.code = 8'($urandom_range(0, 255));
      k.rt   = 2'($urandom_range(0, 3));
      if (k.rt < TERMINALS && line_len[k.rt] > 0 && $urandom_range(0, 9) < 7)
        k.ri = 7'($urandom_range(0, line_len[k.rt] - 1));
      else
        k.ri = 7'($urandom_range(0, 127));
      keystrokes.push_back(k);
    end else if (pick < 56) begin
      push_scan(modifiers[$urandom_range(0, 8)]);
    end else if (pick < 62) begin
      push_scan(SC_BKSP);
    end else if (pick < 66) begin
      push_scan(SC_ENTER);
    end else if (pick < 70) begin
      push_scan(SC_CTRL);
      push_scan(SC_KEY_L);
      push_scan(SC_CTRL_REL);
    end else if (pick < 76) begin
      push_scan(SC_ALT);
      push_scan(SC_F1_REL + 8'($urandom_range(0, 3)));
      push_scan(SC_ALT_REL);
    end else if (pick < 86) begin
      push_scan(8'($urandom_range(0, 255)));
    end else begin
      push_scan(random_printable() | ($urandom_range(0, 1) ? SC_RELEASE : 8'h00));
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("no completion within %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int         sent;
    logic       en;
    keystroke_t k;
    stim_row_t  row;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_SCAN;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    error_count   = 0;
    results_seen  = 0;
    full_refusals = 0;
    enable_writes = 0;
    calm_left     = '{0, 0};
    for (int a = 0; a < 8; a++) act_count[a] = 0;
    reset_mirror();

    // cfg, req, code, terminal, index, typed, action, char
    dir_rows = '{
      {1'b0, REQ_LINE_READ, 8'h00,         2'd0, 7'd0,   1'b1, ACT_READ,   8'h00},
      {1'b0, REQ_SCAN,      8'h1E,         2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_ENTER,      2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_BKSP,       2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b1, REQ_SCAN,      8'h01,         2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      8'h02,         2'd3, 7'd127, 1'b1, ACT_ADD,    "1"},
      {1'b0, REQ_SCAN,      SC_LSHIFT,     2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      8'h02,         2'd0, 7'd0,   1'b1, ACT_ADD,    "!"},
      {1'b0, REQ_SCAN,      8'h10,         2'd0, 7'd0,   1'b1, ACT_ADD,    "Q"},
      {1'b0, REQ_SCAN,      SC_CAPS,       2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      8'h10,         2'd0, 7'd0,   1'b1, ACT_ADD,    "q"},
      {1'b0, REQ_SCAN,      SC_LSHIFT_REL, 2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      8'h2C,         2'd0, 7'd0,   1'b1, ACT_ADD,    "Z"},
      {1'b0, REQ_SCAN,      SC_BKSP,       2'd0, 7'd0,   1'b1, ACT_BKSP,   8'h00},
      {1'b0, REQ_SCAN,      8'h39,         2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_ENTER,      2'd0, 7'd0,   1'b1, ACT_ENTER,  CH_NEWLINE},
      {1'b0, REQ_SCAN,      SC_BKSP,       2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_LINE_READ, 8'hFF,         2'd0, 7'd0,   1'b1, ACT_READ,   "1"},
      {1'b0, REQ_LINE_READ, 8'h00,         2'd0, 7'd127, 1'b1, ACT_READ,   8'h00},
      {1'b0, REQ_LINE_READ, 8'h00,         2'd3, 7'd5,   1'b1, ACT_READ,   8'h00},
      {1'b0, REQ_SCAN,      SC_ALT,        2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_F3_REL,     2'd0, 7'd0,   1'b1, ACT_SWITCH, 8'h00},
      {1'b0, REQ_SCAN,      8'hBE,         2'd0, 7'd0,   1'b1, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_ALT_REL,    2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_CTRL,       2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00},
      {1'b0, REQ_SCAN,      SC_KEY_L,      2'd0, 7'd0,   1'b1, ACT_CLEAR,  8'h00},
      {1'b0, REQ_SCAN,      SC_CTRL_REL,   2'd0, 7'd0,   1'b0, ACT_NONE,   8'h00}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.cfg) begin
        drain_results();
        write_input_enable(row.code[0]);
      end else begin
        k.req  = row.req;
        k.code = row.code;
        k.rt   = row.rt;
        k.ri   = row.ri;
        send_item(k, row.typed, row.act, row.ch);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      en = (p == 1 || p == 4) ? 1'b0 : 1'b1;
      write_input_enable(en);
      sent = 0;
      while (sent < PHASE_ITEMS || keystrokes.size() != 0) begin
        if (keystrokes.size() == 0) plan_keystrokes();
        k = keystrokes.pop_front();
        send_item(k, 1'b0, ACT_NONE, 8'h00);
        sent++;
      end
    end
    drain_results();

    $display("%0d results checked: %0d chars added, %0d erased, %0d lines ended, %0d reads",
             results_seen, act_count[ACT_ADD], act_count[ACT_BKSP], act_count[ACT_ENTER],
             act_count[ACT_READ]);
    $display("%0d clears, %0d terminal switches, %0d keys refused on a full line, %0d %s",
             act_count[ACT_CLEAR], act_count[ACT_SWITCH], full_refusals, enable_writes,
             "enable writes");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_ctrl.sv
rtl/core/scancode_line_editor_core.sv
bench/tb.sv
